FILE: hdl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// Depends on nothing; every other file of the block uses it by scoped names.
package hsv2rgb_pkg;

  // Default channel scale: full scale is 2**CHANNEL_BITS - 1
  localparam int CHANNEL_BITS_DEF = 8;

  // Field widths of the stream payloads
  localparam int HUE_W   = 9;
  localparam int CHAN_W  = 8;
  localparam int REM_W   = 6;
  localparam int PART_W  = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Hue geometry in whole degrees
  localparam int HUE_MAX    = 360;
  localparam int SECTOR_DEG = 60;

  // Largest v*s*part product for 8-bit saturation and value
  localparam int VSP_MAX = 255 * 255 * SECTOR_DEG;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Back pipeline depth (five arithmetic stages plus the output register)
  localparam int BACK_STAGES = 6;

  // Hue sector; hue of exactly 360 maps onto SEC_0
  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

  // One classified pixel request as held in the queue
  typedef struct packed {
    sector_t                 sector;
    logic [REM_W-1:0]        rem;
    logic [CHAN_W-1:0]       sat;
    logic [CHAN_W-1:0]       val;
  } item_t;

  // Sideband that rides along the back pipeline
  typedef struct packed {
    sector_t                 sector;
    logic [CHAN_W-1:0]       val;
  } meta_t;

endpackage

FILE: hdl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: front, request queue and back pipeline.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_queue and hsv2rgb_back.
//
//   channel | direction | payload (low bit up)
//   in_     | slave     | tdata: hue[8:0], saturation[16:9], brightness[24:17], zero pad
//   out_    | master    | tdata: red[7:0], green[15:8], blue[23:16]
//
// One pixel enters per clock while the queue has room; one result leaves per clock when taken.
// A request passes the queue entry, then the arithmetic stages and the output register.
// The back pipeline halts as a whole only while its output register holds an untaken result.
// The four-entry queue absorbs the front while the back is halted.
// Reset (rst_n low, synchronous) empties the queue and clears all valid bits.
module hsv_to_rgb_converter #(
  parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // hue[8:0], saturation[16:9], brightness[24:17], zero[31:25]
  input  logic [hsv2rgb_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [hsv2rgb_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_vld;
  hsv2rgb_pkg::item_t q_wr_item;
  hsv2rgb_pkg::item_t q_rd_item;

  // Classify requests
  hsv2rgb_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  // Decouple front and back
  hsv2rgb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_vld  (q_vld),
    .rd_item (q_rd_item)
  );

  // Compute and drive results
  hsv2rgb_back #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: hdl/hsv2rgb_front.sv
// Front part: takes input requests, clamps the hue and splits it into sector and remainder.
// Depends on hsv2rgb_pkg; feeds hsv2rgb_queue.
module hsv2rgb_front #(
  parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [hsv2rgb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                                 q_full,
  output logic                                 q_push,
  output hsv2rgb_pkg::item_t                   q_item
);

  localparam int CW = hsv2rgb_pkg::CHAN_W;
  localparam int HW = hsv2rgb_pkg::HUE_W;
  // Mask that limits saturation and value to the channel scale
  localparam logic [CW-1:0] CHAN_MASK =
    (CHANNEL_BITS >= CW) ? {CW{1'b1}} : CW'((1 << CHANNEL_BITS) - 1);
  localparam logic [HW-1:0] HUE_MAX_H = HW'(hsv2rgb_pkg::HUE_MAX);
  localparam logic [HW-1:0] DEG       = HW'(hsv2rgb_pkg::SECTOR_DEG);

  logic [HW-1:0] hue;
  logic [HW-1:0] hue_c;
  logic [HW-1:0] base;
  hsv2rgb_pkg::sector_t sector;

  assign hue = in_tdata[HW-1:0];

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Clamp the hue and find its sector by comparison against sector bounds
  always_comb begin
    hue_c  = (hue > HUE_MAX_H) ? HUE_MAX_H : hue;
    sector = hsv2rgb_pkg::SEC_0;
    base   = '0;
    if (hue_c < DEG) begin
      sector = hsv2rgb_pkg::SEC_0;
      base   = '0;
    end else if (hue_c < HW'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sector = hsv2rgb_pkg::SEC_1;
      base   = DEG;
    end else if (hue_c < HW'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sector = hsv2rgb_pkg::SEC_2;
      base   = HW'(2 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (hue_c < HW'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sector = hsv2rgb_pkg::SEC_3;
      base   = HW'(3 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (hue_c < HW'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sector = hsv2rgb_pkg::SEC_4;
      base   = HW'(4 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (hue_c < HUE_MAX_H) begin
      sector = hsv2rgb_pkg::SEC_5;
      base   = HW'(5 * hsv2rgb_pkg::SECTOR_DEG);
    end else begin
      // full circle wraps to the first sector with zero remainder
      sector = hsv2rgb_pkg::SEC_0;
      base   = HUE_MAX_H;
    end
  end

  // Build the queue entry
  always_comb begin
    q_item.sector = sector;
    q_item.rem    = hsv2rgb_pkg::REM_W'(hue_c - base);
    q_item.sat    = in_tdata[HW +: CW] & CHAN_MASK;
    q_item.val    = in_tdata[HW + CW +: CW] & CHAN_MASK;
  end

endmodule

FILE: hdl/hsv2rgb_queue.sv
// Short request queue between the front and the back parts.
// Depends on hsv2rgb_pkg for the entry type and depth.
module hsv2rgb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hsv2rgb_pkg::item_t wr_item,
  output logic               full,
  input  logic               pop,
  output logic               rd_vld,
  output hsv2rgb_pkg::item_t rd_item
);

  localparam int PW = hsv2rgb_pkg::QPTR_W;
  localparam int QD = hsv2rgb_pkg::QUEUE_DEPTH;

  hsv2rgb_pkg::item_t mem_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_pop;

  assign full    = (cnt_r == (PW + 1)'(QD));
  assign rd_vld  = (cnt_r != '0);
  assign rd_item = mem_r[rd_ptr_r];
  assign do_pop  = pop && rd_vld;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: hdl/hsv2rgb_back.sv
// Back part: computes p, q and t in three lanes and maps them onto red, green and blue.
// Depends on hsv2rgb_pkg; reads from hsv2rgb_queue and drives the result stream.
module hsv2rgb_back #(
  parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_vld,
  input  hsv2rgb_pkg::item_t                   q_item,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [hsv2rgb_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // Each term is v - ceil(v*s*part / D) with D = M*60 and part in {60, r, 60-r}.
  // The ceiling is floor((v*s*part + D-1) / D), taken by a reciprocal
  // multiply that may fall one short, then one compare and increment.
  localparam int CW   = hsv2rgb_pkg::CHAN_W;
  localparam int PTW  = hsv2rgb_pkg::PART_W;
  localparam int M    = (1 << CHANNEL_BITS) - 1;
  localparam int D    = M * hsv2rgb_pkg::SECTOR_DEG;
  localparam int XW   = $clog2(hsv2rgb_pkg::VSP_MAX + D);
  localparam int RCP  = (2 ** XW) / D;
  localparam int RW   = $clog2(RCP + 1);
  localparam int EW   = CW + 1;
  localparam int VSW  = 2 * CW;
  localparam int NL   = 3;
  localparam logic [XW-1:0] D_X    = XW'(D);
  localparam logic [XW-1:0] DM1_X  = XW'(D - 1);
  localparam logic [PTW-1:0] DEG_P = PTW'(hsv2rgb_pkg::SECTOR_DEG);

  // Lane order: p, q, t
  localparam int LP = 0;
  localparam int LQ = 1;
  localparam int LT = 2;

  logic adv;

  logic [4:0] vld_r;
  logic       out_vld_r;

  hsv2rgb_pkg::meta_t meta1_r, meta2_r, meta3_r, meta4_r, meta5_r;
  logic [VSW-1:0]     vs1_r;
  logic [PTW-1:0]     part1_r [NL];
  logic [XW-1:0]      x2_r    [NL];
  logic [EW-1:0]      e3_r    [NL];
  logic [XW-1:0]      x3_r    [NL];
  logic [XW-1:0]      ed4_r   [NL];
  logic [EW-1:0]      e4_r    [NL];
  logic [XW-1:0]      x4_r    [NL];
  logic [CW-1:0]      term5_r [NL];
  logic [CW-1:0]      red_r, green_r, blue_r;
  logic [CW-1:0]      red_nxt, green_nxt, blue_nxt;

  // Move the whole pipeline unless the output holds a result that is not taken
  assign adv        = !out_vld_r || out_tready;
  assign q_pop      = adv && q_vld;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {blue_r, green_r, red_r};

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[3:0], q_vld};
      out_vld_r <= vld_r[4];
    end
  end

  // Arithmetic stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: v*s and the three sector fractions
      vs1_r          <= VSW'(q_item.val) * VSW'(q_item.sat);
      part1_r[LP]    <= DEG_P;
      part1_r[LQ]    <= PTW'(q_item.rem);
      part1_r[LT]    <= DEG_P - PTW'(q_item.rem);
      meta1_r.sector <= q_item.sector;
      meta1_r.val    <= q_item.val;
      // stage 2: numerator of the ceiling
      for (int i = 0; i < NL; i++) begin
        x2_r[i] <= XW'(vs1_r) * XW'(part1_r[i]) + DM1_X;
      end
      meta2_r <= meta1_r;
      // stage 3: reciprocal estimate of the quotient
      for (int i = 0; i < NL; i++) begin
        e3_r[i] <= EW'(((XW + RW)'(x2_r[i]) * (XW + RW)'(RCP)) >> XW);
        x3_r[i] <= x2_r[i];
      end
      meta3_r <= meta2_r;
      // stage 4: multiply back for the remainder check
      for (int i = 0; i < NL; i++) begin
        ed4_r[i] <= XW'(e3_r[i]) * D_X;
        e4_r[i]  <= e3_r[i];
        x4_r[i]  <= x3_r[i];
      end
      meta4_r <= meta3_r;
      // stage 5: correct the estimate and subtract from v
      for (int i = 0; i < NL; i++) begin
        term5_r[i] <= CW'(EW'(meta4_r.val) - (e4_r[i] +
                      EW'((x4_r[i] - ed4_r[i]) >= D_X)));
      end
      meta5_r <= meta4_r;
      // output register
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  // Place v, p, q and t by sector
  always_comb begin
    unique case (meta5_r.sector)
      hsv2rgb_pkg::SEC_1: begin
        red_nxt = term5_r[LQ]; green_nxt = meta5_r.val; blue_nxt = term5_r[LP];
      end
      hsv2rgb_pkg::SEC_2: begin
        red_nxt = term5_r[LP]; green_nxt = meta5_r.val; blue_nxt = term5_r[LT];
      end
      hsv2rgb_pkg::SEC_3: begin
        red_nxt = term5_r[LP]; green_nxt = term5_r[LQ]; blue_nxt = meta5_r.val;
      end
      hsv2rgb_pkg::SEC_4: begin
        red_nxt = term5_r[LT]; green_nxt = term5_r[LP]; blue_nxt = meta5_r.val;
      end
      hsv2rgb_pkg::SEC_5: begin
        red_nxt = meta5_r.val; green_nxt = term5_r[LP]; blue_nxt = term5_r[LQ];
      end
      default: begin
        red_nxt = meta5_r.val; green_nxt = term5_r[LT]; blue_nxt = term5_r[LP];
      end
    endcase
  end

endmodule

FILE: hdl/hsv2rgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound onto the top level.
// Depends on hsv2rgb_pkg for queue and pipeline depths.
module hsv2rgb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [hsv2rgb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [hsv2rgb_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int MAX_FLIGHT = hsv2rgb_pkg::QUEUE_DEPTH + hsv2rgb_pkg::BACK_STAGES;
  localparam int FW = $clog2(MAX_FLIGHT + 2);

  logic [FW-1:0] flight_r, flight_nxt;
  logic          in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Track requests accepted but not yet delivered
  always_comb begin
    flight_nxt = flight_r;
    if (in_acc && !out_acc) begin
      flight_nxt = flight_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      flight_nxt = flight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else begin
      flight_r <= flight_nxt;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // Reset empties the pipeline
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // Produce no result without a request in flight
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> flight_r != '0)
    else $error("result without an accepted request");

  // Bound the requests in flight by queue plus pipeline depth
  a_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flight_r <= FW'(MAX_FLIGHT))
    else $error("more requests in flight than storage");

  // Refuse requests only while requests are in flight
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> flight_r != '0)
    else $error("request refused while empty");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
